// ===== hw/rtl/bgc_pkg.sv =====
// Shared types and constants for the button gesture classifier.
`default_nettype none

package bgc_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE         = CFG_INDEX_W'(3);

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd500;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd250;
  localparam logic [CFG_W-1:0] IDLE_RST         = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [CFG_W-1:0] idle_ms;
  } bgc_cfg_t;

  typedef struct packed {
    logic debounced_level;
    logic waiting_double;
    logic waiting_long;
    logic idle_reported;
    logic last_was_single;
    logic last_was_double;
    logic last_was_long;
  } bgc_flags_t;

  typedef struct packed {
    logic edge_accepted;
    logic stable_level;
    logic double_click;
    logic long_press;
    logic single_click;
    logic no_click;
  } bgc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgc_step.sv =====
// Next-state and event logic for one millisecond tick of the classifier.
`default_nettype none

module bgc_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                      button_level,
  input  bgc_pkg::bgc_cfg_t        cfg,
  input  bgc_pkg::bgc_flags_t      flags,
  input  wire  [COUNT_WIDTH-1:0]   ticks_since_edge,
  input  wire  [COUNT_WIDTH-1:0]   ticks_since_press,
  output bgc_pkg::bgc_flags_t      flags_nxt,
  output logic [COUNT_WIDTH-1:0]   ticks_since_edge_nxt,
  output logic [COUNT_WIDTH-1:0]   ticks_since_press_nxt,
  output bgc_pkg::bgc_result_t     result
);

  // compare width covers both the counters and the 16-bit thresholds
  localparam int unsigned CMP_W =
    (COUNT_WIDTH > bgc_pkg::CFG_W) ? COUNT_WIDTH : bgc_pkg::CFG_W;

  logic [CMP_W-1:0] deb_x, long_x, dbl_x, idle_x;

  assign deb_x  = CMP_W'(cfg.debounce_ms);
  assign long_x = CMP_W'(cfg.long_press_ms);
  assign dbl_x  = CMP_W'(cfg.double_click_ms);
  assign idle_x = CMP_W'(cfg.idle_ms);

  always_comb begin
    bgc_pkg::bgc_flags_t    f;
    bgc_pkg::bgc_result_t   r;
    logic [COUNT_WIDTH-1:0] tse;
    logic [COUNT_WIDTH-1:0] tsp;
    logic                   raw;

    f   = flags;
    r   = '0;
    raw = button_level;

    // advance both counters, saturating
    tse = (&ticks_since_edge)  ? ticks_since_edge  : ticks_since_edge + 1'b1;
    tsp = (&ticks_since_press) ? ticks_since_press : ticks_since_press + 1'b1;

    if ((raw != f.debounced_level) && (CMP_W'(tse) > deb_x)) begin
      f.idle_reported   = 1'b0;
      f.debounced_level = raw;
      tse               = '0;
      r.edge_accepted   = 1'b1;
      if (!raw) begin
        f.waiting_long   = 1'b1;
        f.waiting_double = 1'b1;
        if (CMP_W'(tsp) < dbl_x) begin
          f.waiting_double  = 1'b0;
          f.last_was_single = 1'b0;
          f.last_was_double = 1'b1;
          f.last_was_long   = 1'b0;
          r.double_click    = 1'b1;
        end
        tsp = '0;
      end
    end

    if (!raw && (CMP_W'(tse) > long_x) && !f.last_was_long) begin
      f.last_was_long   = 1'b1;
      f.waiting_long    = 1'b0;
      f.last_was_single = 1'b0;
      f.last_was_double = 1'b0;
      r.long_press      = 1'b1;
    end

    if (raw && !f.last_was_double && !f.waiting_double && !f.waiting_long &&
        !f.idle_reported && !f.last_was_single) begin
      f.last_was_single = 1'b1;
      f.last_was_double = 1'b0;
      f.last_was_long   = 1'b0;
      r.single_click    = 1'b1;
    end

    if (raw && (CMP_W'(tse) > idle_x) && !f.idle_reported) begin
      f.idle_reported   = 1'b1;
      f.waiting_double  = 1'b0;
      f.waiting_long    = 1'b0;
      f.last_was_single = 1'b0;
      f.last_was_double = 1'b0;
      f.last_was_long   = 1'b0;
      r.no_click        = 1'b1;
    end

    // drop the double-click wait once the window has passed
    if (raw && (CMP_W'(tse) > dbl_x) && f.waiting_double) begin
      f.waiting_double = 1'b0;
    end

    if (raw && f.waiting_long) begin
      f.waiting_long = 1'b0;
    end

    r.stable_level = f.debounced_level;

    flags_nxt             = f;
    ticks_since_edge_nxt  = tse;
    ticks_since_press_nxt = tsp;
    result                = r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/button_gesture_classifier.sv =====
// Top level of the button gesture classifier: configuration, tick state and result register.
`default_nettype none

// A result is registered and offered in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the result register lets a new tick enter while
// the previous result is still offered, so only a stalled, full result register holds the input.
// Reset (synchronous, rst_n low): registers return to their default thresholds,
// counters and flags clear, the result register empties.
module button_gesture_classifier #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,

  input  wire                             cfg_we,
  input  wire  [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [bgc_pkg::CFG_W-1:0]       cfg_wdata,

  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_button_level,

  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_edge_accepted,
  output logic                            out_stable_level,
  output logic                            out_double_click,
  output logic                            out_long_press,
  output logic                            out_single_click,
  output logic                            out_no_click
);

  bgc_pkg::bgc_cfg_t    cfg_r;
  bgc_pkg::bgc_flags_t  flags_r, flags_nxt;
  bgc_pkg::bgc_result_t res_r, res_nxt;

  logic [COUNT_WIDTH-1:0] tse_r, tse_nxt;
  logic [COUNT_WIDTH-1:0] tsp_r, tsp_nxt;
  logic                   out_valid_r;
  logic                   in_take;
  logic                   out_take;

  // Hold the input only while a result waits and the far side stalls.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= bgc_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms   <= bgc_pkg::LONG_PRESS_RST;
      cfg_r.double_click_ms <= bgc_pkg::DOUBLE_CLICK_RST;
      cfg_r.idle_ms         <= bgc_pkg::IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bgc_pkg::REG_DEBOUNCE:     cfg_r.debounce_ms     <= cfg_wdata;
        bgc_pkg::REG_LONG_PRESS:   cfg_r.long_press_ms   <= cfg_wdata;
        bgc_pkg::REG_DOUBLE_CLICK: cfg_r.double_click_ms <= cfg_wdata;
        bgc_pkg::REG_IDLE:         cfg_r.idle_ms         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bgc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .button_level          (in_button_level),
    .cfg                   (cfg_r),
    .flags                 (flags_r),
    .ticks_since_edge      (tse_r),
    .ticks_since_press     (tsp_r),
    .flags_nxt             (flags_nxt),
    .ticks_since_edge_nxt  (tse_nxt),
    .ticks_since_press_nxt (tsp_nxt),
    .result                (res_nxt)
  );

  // Advance the tick state once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      tse_r   <= '0;
      tsp_r   <= '0;
    end else if (in_take) begin
      flags_r <= flags_nxt;
      tse_r   <= tse_nxt;
      tsp_r   <= tsp_nxt;
    end
  end

  // Result register: load on each accepted tick, empty when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_accepted = res_r.edge_accepted;
  assign out_stable_level  = res_r.stable_level;
  assign out_double_click  = res_r.double_click;
  assign out_long_press    = res_r.long_press;
  assign out_single_click  = res_r.single_click;
  assign out_no_click      = res_r.no_click;

`ifndef SYNTHESIS
  // A double click only comes with an accepted press edge.
  a_dbl_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.double_click |-> res_r.edge_accepted && !res_r.stable_level)
    else $error("double click without an accepted press edge");

  // Long press needs the button held; single and no click need it released.
  a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.long_press |-> !res_r.single_click && !res_r.no_click)
    else $error("long press reported together with a release event");

  // An accepted edge flips the debounced level and restarts the edge counter.
  a_edge_flips_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && res_nxt.edge_accepted |=>
      (flags_r.debounced_level != $past(flags_r.debounced_level)) && (tse_r == '0))
    else $error("accepted edge did not update debounced level");

  // The reported level matches the debounced state that the tick produced.
  a_level_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> res_r.stable_level == flags_r.debounced_level)
    else $error("reported level differs from debounced state");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_button_gesture_classifier.sv =====
// Self-checking testbench for the button gesture classifier: tick stimulus, predictor, checks.

module tb_button_gesture_classifier;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 20000;
  // Receiver hold-off used to fill the block and back-pressure its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // Directed tick levels, sent MSB first: release, long press, release, a short press.
  localparam logic [23:0] PROBE_LEVELS = 24'b1111_0000_0000_1111_1111_1011;
  localparam logic [4:0]  ZERO_LEVELS  = 5'b10110;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_TICKS  = 258;

  // Gesture predictor and store of expected tick results.
  class tick_scoreboard;
    bgc_pkg::bgc_cfg_t    cfg;
    logic                 level;
    logic [15:0]          since_edge;
    logic [15:0]          since_press;
    logic                 wait_dbl;
    logic                 wait_long;
    logic                 idle_done;
    logic                 was_single;
    logic                 was_double;
    logic                 was_long;
    bgc_pkg::bgc_result_t pending[$];
    int unsigned          errors;
    int unsigned          results_seen;
    string                field_names[6] = '{"edge_accepted", "stable_level", "double_click",
                                             "long_press", "single_click", "no_click"};

    function new();
      cfg = '{bgc_pkg::DEBOUNCE_RST, bgc_pkg::LONG_PRESS_RST, bgc_pkg::DOUBLE_CLICK_RST,
              bgc_pkg::IDLE_RST};
      level = 1'b0;
      since_edge = '0;
      since_press = '0;
      {wait_dbl, wait_long, idle_done, was_single, was_double, was_long} = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [bgc_pkg::CFG_INDEX_W-1:0] idx,
                            logic [bgc_pkg::CFG_W-1:0] val);
      case (idx)
        bgc_pkg::REG_DEBOUNCE:     cfg.debounce_ms = val;
        bgc_pkg::REG_LONG_PRESS:   cfg.long_press_ms = val;
        bgc_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms = val;
        bgc_pkg::REG_IDLE:         cfg.idle_ms = val;
        default: ;
      endcase
    endfunction

    // Advance the predicted state by one tick and queue the expected result.
    function void note_tick(logic raw);
      bgc_pkg::bgc_result_t r;
      r = '0;
      since_edge = (since_edge == '1) ? since_edge : since_edge + 16'd1;
      since_press = (since_press == '1) ? since_press : since_press + 16'd1;

      if (raw != level && since_edge > cfg.debounce_ms) begin
        idle_done = 1'b0;
        level = raw;
        since_edge = '0;
        r.edge_accepted = 1'b1;
        if (!raw) begin
          wait_long = 1'b1;
          wait_dbl = 1'b1;
          if (since_press < cfg.double_click_ms) begin
            wait_dbl = 1'b0;
            was_single = 1'b0;
            was_double = 1'b1;
            was_long = 1'b0;
            r.double_click = 1'b1;
          end
          since_press = '0;
        end
      end

      if (!raw && since_edge > cfg.long_press_ms && !was_long) begin
        was_long = 1'b1;
        wait_long = 1'b0;
        was_single = 1'b0;
        was_double = 1'b0;
        r.long_press = 1'b1;
      end

      if (raw && !was_double && !wait_dbl && !wait_long && !idle_done && !was_single) begin
        was_single = 1'b1;
        was_double = 1'b0;
        was_long = 1'b0;
        r.single_click = 1'b1;
      end

      if (raw && since_edge > cfg.idle_ms && !idle_done) begin
        idle_done = 1'b1;
        wait_dbl = 1'b0;
        wait_long = 1'b0;
        was_single = 1'b0;
        was_double = 1'b0;
        was_long = 1'b0;
        r.no_click = 1'b1;
      end

      if (raw && since_edge > cfg.double_click_ms && wait_dbl) wait_dbl = 1'b0;
      if (raw && wait_long) wait_long = 1'b0;

      r.stable_level = level;
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(bgc_pkg::bgc_result_t got);
      bgc_pkg::bgc_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d arrived with no tick outstanding", results_seen));
        return;
      end
      want = pending.pop_front();
      for (int b = 5; b >= 0; b--) begin
        if (got[b] !== want[b])
          report($sformatf("result %0d %s: got %b, want %b",
                           results_seen, field_names[5-b], got[b], want[b]));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bgc_pkg::CFG_W-1:0]       cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_button_level = 1'b0;
  logic                            out_stall = 1'b0;
  logic                            in_stall;
  logic                            out_valid;
  logic                            out_edge_accepted;
  logic                            out_stable_level;
  logic                            out_double_click;
  logic                            out_long_press;
  logic                            out_single_click;
  logic                            out_no_click;

  tick_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_ticks = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;

  button_gesture_classifier DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_button_level   (in_button_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_edge_accepted (out_edge_accepted),
    .out_stable_level  (out_stable_level),
    .out_double_click  (out_double_click),
    .out_long_press    (out_long_press),
    .out_single_click  (out_single_click),
    .out_no_click      (out_no_click)
  );

  always #5 clk = ~clk;

  // Receiver: stall at random, or hold off for a long stretch when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: sample both channels at the edge, feed the predictor, check results,
  // and watch for a hung run.
  always @(posedge clk) begin : monitor
    bgc_pkg::bgc_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_button_level);
      if (out_valid && !out_stall) begin
        got = {out_edge_accepted, out_stable_level, out_double_click,
               out_long_press, out_single_click, out_no_click};
        sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
          $display("[button_gesture_classifier] ERROR");
          $finish;
        end
      end
    end
  end

  // Offer one tick, idling first at the sender's rate; hold it until accepted.
  task automatic send_tick(input logic lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_ticks++;
  endtask

  task automatic send_run(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic cfg_write(input logic [bgc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bgc_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Drain the block, then write all four thresholds plus one unmapped index.
  task automatic program_regs(input logic [bgc_pkg::CFG_W-1:0] deb,
                              input logic [bgc_pkg::CFG_W-1:0] lp,
                              input logic [bgc_pkg::CFG_W-1:0] dc,
                              input logic [bgc_pkg::CFG_W-1:0] idl);
    logic [bgc_pkg::CFG_INDEX_W-1:0] stray;
    stray = bgc_pkg::CFG_INDEX_W'($urandom_range(int'(bgc_pkg::REG_IDLE) + 1,
                                                 (1 << bgc_pkg::CFG_INDEX_W) - 1));
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // results are registered: allow a little slack before touching the registers
    repeat (3) @(posedge clk);
    cfg_write(bgc_pkg::REG_DEBOUNCE, deb);
    cfg_write(bgc_pkg::REG_LONG_PRESS, lp);
    cfg_write(bgc_pkg::REG_DOUBLE_CLICK, dc);
    cfg_write(bgc_pkg::REG_IDLE, idl);
    cfg_write(stray, bgc_pkg::CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned scale;
    int unsigned deb;
    int unsigned lp;
    int unsigned dc;
    int unsigned idl;
    int unsigned phase_end;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sender idles lightly, receiver heavily.
    send_idle_pct = 22;
    recv_idle_pct = 85;

    // Small thresholds so that every gesture fits in a few ticks; the first press
    // lands outside the double-click window counted from reset.
    program_regs(16'd2, 16'd6, 16'd5, 16'd8);
    for (int i = 23; i >= 0; i--) send_tick(PROBE_LEVELS[i]);

    // Zero thresholds: any change in level is taken on the tick it appears.
    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 4; i >= 0; i--) send_tick(ZERO_LEVELS[i]);

    // Random part: mostly press/release gestures with bounce, some noise.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 85;
      end else if (p < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      scale = (p == PHASES - 1) ? 8 : 1;
      deb = $urandom_range(0, 4) * scale;
      lp = $urandom_range(2, 25) * scale;
      dc = $urandom_range(1, 15) * scale;
      idl = $urandom_range(5, 40) * scale;
      program_regs(bgc_pkg::CFG_W'(deb), bgc_pkg::CFG_W'(lp), bgc_pkg::CFG_W'(dc),
                   bgc_pkg::CFG_W'(idl));

      // Hold off the receiver while ticks keep coming, so the input backs up.
      if (p == 4) hold_req = 1'b1;

      phase_end = sent_ticks + PHASE_TICKS;
      while (sent_ticks < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              send_tick(1'b0);
              send_tick(1'b1);
            end
          end
          send_run(1'b0, $urandom_range(1, lp + 8));
          if ($urandom_range(0, 1) == 0)
            send_run(1'b1, $urandom_range(1, dc + 3));
          else
            send_run(1'b1, $urandom_range(1, idl + 8));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(1'(($urandom_range(0, 1))));
        end
      end
    end

    // A short burst of noise with no debounce at all.
    program_regs(16'd0, 16'd3, 16'd4, 16'd6);
    repeat (12) send_tick(1'(($urandom_range(0, 1))));

    // Drain and let any stray result show up.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0)
      $display("[button_gesture_classifier] OK");
    else
      $display("[button_gesture_classifier] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bgc_pkg.sv
hw/rtl/bgc_step.sv
hw/rtl/button_gesture_classifier.sv
tb/sv/tb_button_gesture_classifier.sv
